// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the transaction controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OTC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("otc assertion failed");
`define OTC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("otc assertion failed");
`else
`define OTC_ASSERT(name, prop)
`define OTC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/core/otc_pkg.sv
// Types, codes and constants of the transaction controller.
`default_nettype none
package otc_pkg;

   localparam int FRAME_BITS     = 32;
   localparam int CFG_TIME_BITS  = 24;
   localparam int TIMER_BITS_DEF = 24;
   localparam int CMD_BITS       = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;

   localparam logic [CFG_TIME_BITS-1:0] RESPONSE_TIMEOUT_RST = 24'd1000000;
   localparam logic [CFG_TIME_BITS-1:0] SLAVE_GAP_RST        = 24'd20000;
   localparam logic [CFG_TIME_BITS-1:0] MASTER_GAP_RST       = 24'd100000;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SEND_REQUEST   = 3'd0,
      CMD_SEND_RESPONSE  = 3'd1,
      CMD_FRAME_RECEIVED = 3'd2,
      CMD_TICK           = 3'd3,
      CMD_FORCED_SEND    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      REG_IS_SLAVE         = 2'd0,
      REG_RESPONSE_TIMEOUT = 2'd1,
      REG_SLAVE_GAP        = 2'd2,
      REG_MASTER_GAP       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_OK      = 2'd1,
      ST_INVALID = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      LS_READY   = 3'd0,
      LS_WAIT    = 3'd1,
      LS_FRAME   = 3'd2,
      LS_BAD     = 3'd3,
      LS_DELAY   = 3'd4
   } link_code_type;

   typedef struct packed {
      logic                     is_slave;
      logic [CFG_TIME_BITS-1:0] response_timeout;
      logic [CFG_TIME_BITS-1:0] slave_gap;
      logic [CFG_TIME_BITS-1:0] master_gap;
   } cfg_type;

   typedef struct packed {
      logic                  accepted;
      logic                  tx_valid;
      logic [FRAME_BITS-1:0] tx_frame;
      logic                  report_valid;
      logic [FRAME_BITS-1:0] frame_out;
      status_type            frame_status;
      link_code_type         link_state;
   } result_type;

   // even parity and a type field allowed for the current role
   function automatic logic frame_ok(input logic [FRAME_BITS-1:0] frame,
                                     input logic is_slave);
      logic kind_ok;
      kind_ok = is_slave ? (frame[30:29] == 2'b00) : (frame[30:29] == 2'b10);
      return !(^frame) && kind_ok;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/otc_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module otc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [otc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [otc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [otc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output otc_pkg::cfg_type                          cfg
);
   import otc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign write_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_IS_SLAVE:         cfg_in.is_slave         = pwdata[0];
            REG_RESPONSE_TIMEOUT: cfg_in.response_timeout = pwdata[CFG_TIME_BITS-1:0];
            REG_SLAVE_GAP:        cfg_in.slave_gap        = pwdata[CFG_TIME_BITS-1:0];
            REG_MASTER_GAP:       cfg_in.master_gap       = pwdata[CFG_TIME_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.is_slave         <= 1'b0;
         cfg_ff.response_timeout <= RESPONSE_TIMEOUT_RST;
         cfg_ff.slave_gap        <= SLAVE_GAP_RST;
         cfg_ff.master_gap       <= MASTER_GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_IS_SLAVE:         prdata = CSR_DATA_BITS'(cfg_ff.is_slave);
         REG_RESPONSE_TIMEOUT: prdata = CSR_DATA_BITS'(cfg_ff.response_timeout);
         REG_SLAVE_GAP:        prdata = CSR_DATA_BITS'(cfg_ff.slave_gap);
         REG_MASTER_GAP:       prdata = CSR_DATA_BITS'(cfg_ff.master_gap);
         default:              prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: rtl/core/otc_link.sv
// Link state machine, stored frame, status and elapsed-tick counter.
`default_nettype none
module otc_link #(
   parameter int TIMER_BITS = otc_pkg::TIMER_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_en,
   input  wire logic [otc_pkg::CMD_BITS-1:0]      cmd,
   input  wire logic [otc_pkg::FRAME_BITS-1:0]    frame,
   input  otc_pkg::cfg_type                       cfg,
   output otc_pkg::result_type                    result
);
   import otc_pkg::*;

   localparam int CmpBits = (TIMER_BITS > CFG_TIME_BITS) ? TIMER_BITS : CFG_TIME_BITS;

   typedef enum logic [4:0] {
      PH_READY = 5'b00001,
      PH_WAIT  = 5'b00010,
      PH_FRAME = 5'b00100,
      PH_BAD   = 5'b01000,
      PH_DELAY = 5'b10000
   } phase_type;

   phase_type               phase_ff,  phase_in;
   logic [FRAME_BITS-1:0]   stored_frame_ff, stored_frame_in;
   status_type              status_ff, status_in;
   logic [TIMER_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [TIMER_BITS-1:0]   elapsed_inc;
   logic [CFG_TIME_BITS-1:0] gap;
   logic                    timeout_hit;
   logic                    gap_hit;
   logic                    accepted;
   logic                    tx_valid;
   logic [FRAME_BITS-1:0]   tx_frame;
   logic                    report_valid;

   function automatic link_code_type phase_code(input phase_type ph);
      link_code_type code;
      unique case (ph)
         PH_READY: code = LS_READY;
         PH_WAIT:  code = LS_WAIT;
         PH_FRAME: code = LS_FRAME;
         PH_BAD:   code = LS_BAD;
         PH_DELAY: code = LS_DELAY;
         default:  code = LS_READY;
      endcase
      return code;
   endfunction

   assign elapsed_inc = (elapsed_ff == {TIMER_BITS{1'b1}}) ? elapsed_ff
                                                            : elapsed_ff + 1'b1;
   assign gap         = cfg.is_slave ? cfg.slave_gap : cfg.master_gap;
   assign timeout_hit = CmpBits'(elapsed_inc) > CmpBits'(cfg.response_timeout);
   assign gap_hit     = CmpBits'(elapsed_inc) > CmpBits'(gap);

   always_comb begin
      phase_in        = phase_ff;
      stored_frame_in = stored_frame_ff;
      status_in       = status_ff;
      elapsed_in      = elapsed_ff;
      accepted        = 1'b0;
      tx_valid        = 1'b0;
      tx_frame        = '0;
      report_valid    = 1'b0;
      unique case (cmd)
         CMD_SEND_REQUEST: begin
            if (phase_ff == PH_READY) begin
               accepted        = 1'b1;
               tx_valid        = 1'b1;
               tx_frame        = frame;
               stored_frame_in = '0;
               status_in       = ST_NONE;
               elapsed_in      = '0;
               phase_in        = PH_WAIT;
            end
         end
         CMD_SEND_RESPONSE: begin
            if (phase_ff == PH_READY || phase_ff == PH_DELAY) begin
               accepted        = 1'b1;
               tx_valid        = 1'b1;
               tx_frame        = frame;
               stored_frame_in = '0;
               status_in       = ST_NONE;
               phase_in        = PH_READY;
            end
         end
         CMD_FRAME_RECEIVED: begin
            if (frame != '0) begin
               stored_frame_in = frame;
               elapsed_in      = '0;
               status_in       = frame_ok(frame, cfg.is_slave) ? ST_OK : ST_INVALID;
               phase_in        = PH_FRAME;
            end else if (phase_ff == PH_WAIT) begin
               elapsed_in = '0;
               phase_in   = PH_BAD;
            end
         end
         CMD_TICK: begin
            elapsed_in = elapsed_inc;
            if (phase_ff != PH_READY) begin
               if (phase_ff != PH_DELAY && timeout_hit) begin
                  phase_in     = PH_READY;
                  status_in    = ST_TIMEOUT;
                  report_valid = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_BAD: begin
                        phase_in     = PH_DELAY;
                        status_in    = ST_INVALID;
                        report_valid = 1'b1;
                     end
                     PH_FRAME: begin
                        phase_in     = PH_DELAY;
                        status_in    = frame_ok(stored_frame_ff, cfg.is_slave) ? ST_OK
                                                                              : ST_INVALID;
                        report_valid = 1'b1;
                     end
                     PH_DELAY: begin
                        if (gap_hit) begin
                           phase_in = PH_READY;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
         CMD_FORCED_SEND: begin
            accepted        = 1'b1;
            tx_valid        = 1'b1;
            tx_frame        = frame;
            stored_frame_in = '0;
            status_in       = ST_NONE;
            elapsed_in      = '0;
            phase_in        = PH_READY;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_READY;
         stored_frame_ff <= '0;
         status_ff       <= ST_NONE;
         elapsed_ff      <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         stored_frame_ff <= stored_frame_in;
         status_ff       <= status_in;
         elapsed_ff      <= elapsed_in;
      end
   end

   always_comb begin
      result.accepted     = accepted;
      result.tx_valid     = tx_valid;
      result.tx_frame     = tx_frame;
      result.report_valid = report_valid;
      result.frame_out    = stored_frame_in;
      result.frame_status = status_in;
      result.link_state   = phase_code(phase_in);
   end

endmodule
`default_nettype wire

// File: rtl/core/opentherm_transaction_controller.sv
// Top level: input register, link engine, result register and config port.
//
//   channel | ports        | handshake             | payload
//   input   | req_*        | req_valid / req_stall | command, frame_in
//   result  | rsp_*        | rsp_valid / rsp_stall | accepted .. link_state
//   config  | csr_*        | APB-style, pready = 1 | 4 registers at 4*i
//
// One item per cycle while the result register is not stalled: an item is
// registered in the input register and then moves on to the result register.
// The input register takes a new item while a result waits in the stalled
// result register; req_stall rises only when both registers are full.
// Synchronous reset clears the link state and the elapsed counter and restores the
// config defaults.
`default_nettype none
`include "assert_macros.svh"
module opentherm_transaction_controller #(
   parameter int TIMER_BITS = otc_pkg::TIMER_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [otc_pkg::CMD_BITS-1:0]       req_command,
   input  wire logic [otc_pkg::FRAME_BITS-1:0]     req_frame_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_accepted,
   output logic                                    rsp_tx_valid,
   output logic      [otc_pkg::FRAME_BITS-1:0]     rsp_tx_frame,
   output logic                                    rsp_report_valid,
   output logic      [otc_pkg::FRAME_BITS-1:0]     rsp_frame_out,
   output logic      [1:0]                         rsp_frame_status,
   output logic      [2:0]                         rsp_link_state,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [otc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [otc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [otc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready
);
   import otc_pkg::*;

   cfg_type               cfg;
   result_type            result;
   result_type            out_ff,  out_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  in_valid_ff,  in_valid_in;
   logic [CMD_BITS-1:0]   cmd_ff,   cmd_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  req_take;
   logic                  advance;
   logic                  out_report;
   logic                  out_send;
   logic                  out_send_state_ok;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      cmd_in       = req_take ? req_command  : cmd_ff;
      frame_in     = req_take ? req_frame_in : frame_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      out_in       = advance ? result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      frame_ff <= frame_in;
      out_ff   <= out_in;
   end

   otc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   otc_link #(
      .TIMER_BITS (TIMER_BITS)
   ) u_link (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cmd     (cmd_ff),
      .frame   (frame_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign csr_pready       = 1'b1;
   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = out_ff.accepted;
   assign rsp_tx_valid     = out_ff.tx_valid;
   assign rsp_tx_frame     = out_ff.tx_frame;
   assign rsp_report_valid = out_ff.report_valid;
   assign rsp_frame_out    = out_ff.frame_out;
   assign rsp_frame_status = out_ff.frame_status;
   assign rsp_link_state   = out_ff.link_state;

   assign out_report        = out_valid_ff && out_ff.report_valid;
   assign out_send          = out_valid_ff && out_ff.accepted;
   assign out_send_state_ok = out_ff.link_state == LS_READY || out_ff.link_state == LS_WAIT;

   `OTC_ASSERT(a_no_overwrite, !(advance && out_valid_ff && rsp_stall))
   `OTC_ASSERT(a_tx_needs_accept, !(out_valid_ff && out_ff.tx_valid && !out_ff.accepted))
   `OTC_ASSERT(a_report_has_status, !(out_report && out_ff.frame_status == ST_NONE))
   `OTC_ASSERT(a_send_leaves_idle, !(out_send && !out_send_state_ok))
   `OTC_ASSERT_NEXT(a_stall_holds_item, in_valid_ff && !advance, in_valid_ff && $stable(frame_ff))

endmodule
`default_nettype wire
